### rtl/hof_pkg.sv
package hof_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int SCALE_BITS  = 8;
    localparam int NSLOT       = 9;
    localparam int SLOT_BITS   = 4;
    localparam int QDEPTH      = 2;
    localparam int PDATA_BITS  = 32;
    localparam int PADDR_BITS  = 3;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 8'd72;
    localparam logic                  REG_THRESHOLD_SCALE = 1'b0;

    typedef logic [SAMPLE_BITS-1:0]            sample_t;
    typedef logic [NSLOT-1:0][SAMPLE_BITS-1:0] window_t;

    typedef enum logic [2:0] {
        FILL_MID    = 3'd0,
        FILL_INNER  = 3'd1,
        FILL_MIDDLE = 3'd2,
        FILL_OUTER  = 3'd3,
        FILL_EDGE   = 3'd4,
        STREAM      = 3'd5
    } phase_t;

    typedef struct packed {
        sample_t sample;
        logic    frame_end;
    } item_t;

    typedef struct packed {
        sample_t filtered_sample;
        logic    result_end;
    } result_t;

    typedef struct packed {
        window_t win;
        sample_t center;
        logic    last;
    } snap_t;

    function automatic sample_t min3(sample_t a, sample_t b, sample_t c);
        sample_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic sample_t max3(sample_t a, sample_t b, sample_t c);
        sample_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic sample_t med3(sample_t a, sample_t b, sample_t c);
        return max3((a < b) ? a : b, (a < c) ? a : c, (b < c) ? b : c);
    endfunction

    function automatic sample_t absdiff(sample_t a, sample_t b);
        return (a >= b) ? sample_t'(a - b) : sample_t'(b - a);
    endfunction

endpackage

### rtl/hof_front.sv
module hof_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  hof_pkg::item_t  item,
    output hof_pkg::snap_t  snap
);

    hof_pkg::phase_t                  phase_reg, phase_next;
    logic [hof_pkg::SLOT_BITS-1:0]    slot_pointer_reg, slot_pointer_next;
    hof_pkg::window_t                 window_reg, window_next;
    hof_pkg::sample_t                 held_center_reg, held_center_next;
    logic [hof_pkg::SLOT_BITS-1:0]    sp;
    logic [hof_pkg::SLOT_BITS-1:0]    cidx;
    hof_pkg::sample_t                 center;
    hof_pkg::sample_t                 s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= hof_pkg::FILL_MID;
            slot_pointer_reg <= '0;
            window_reg       <= '0;
            held_center_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            slot_pointer_reg <= slot_pointer_next;
            window_reg       <= window_next;
            held_center_reg  <= held_center_next;
        end
    end

    always_comb
    begin
        s  = item.sample;
        // wrap a stray pointer before use
        sp = (slot_pointer_reg >= hof_pkg::SLOT_BITS'(hof_pkg::NSLOT)) ? '0 : slot_pointer_reg;
        cidx = (sp >= hof_pkg::SLOT_BITS'(hof_pkg::NSLOT - 5))
             ? hof_pkg::SLOT_BITS'(sp - hof_pkg::SLOT_BITS'(hof_pkg::NSLOT - 5))
             : hof_pkg::SLOT_BITS'(sp + hof_pkg::SLOT_BITS'(5));
        window_next       = window_reg;
        center            = held_center_reg;
        slot_pointer_next = sp;
        phase_next        = hof_pkg::STREAM;
        case (phase_reg)
            hof_pkg::FILL_MID:
            begin
                window_next[4] = s;
                phase_next     = hof_pkg::FILL_INNER;
            end
            hof_pkg::FILL_INNER:
            begin
                window_next[3] = s;
                window_next[5] = s;
                phase_next     = hof_pkg::FILL_MIDDLE;
            end
            hof_pkg::FILL_MIDDLE:
            begin
                window_next[2] = s;
                window_next[6] = s;
                phase_next     = hof_pkg::FILL_OUTER;
            end
            hof_pkg::FILL_OUTER:
            begin
                window_next[1] = s;
                window_next[7] = s;
                phase_next     = hof_pkg::FILL_EDGE;
            end
            hof_pkg::FILL_EDGE:
            begin
                window_next[0]    = s;
                window_next[8]    = s;
                center            = window_reg[4];
                slot_pointer_next = '0;
            end
            default:
            begin
                // center slot never equals the written slot
                window_next[sp]   = s;
                center            = window_reg[cidx];
                slot_pointer_next = (sp == hof_pkg::SLOT_BITS'(hof_pkg::NSLOT - 1))
                                  ? '0 : hof_pkg::SLOT_BITS'(sp + 1'b1);
            end
        endcase
        held_center_next = center;
        if (item.frame_end)
        begin
            phase_next        = hof_pkg::FILL_MID;
            slot_pointer_next = '0;
        end
        snap.win    = window_next;
        snap.center = center;
        snap.last   = item.frame_end;
    end

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_pointer_reg < hof_pkg::SLOT_BITS'(hof_pkg::NSLOT))
        else $error("slot pointer out of range");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.frame_end) |=>
            (phase_reg == hof_pkg::FILL_MID) && (slot_pointer_reg == '0))
        else $error("frame end did not restart the fill");

endmodule

### rtl/hof_queue.sv
module hof_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             valid
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : PTR_BITS'(wr_ptr_reg + 1'b1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : PTR_BITS'(rd_ptr_reg + 1'b1);
        end
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = CNT_BITS'(count_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = CNT_BITS'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("queue count overflow");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == CNT_BITS'($past(count_reg) + 1'b1)))
        else $error("queue write lost");

endmodule

### rtl/hof_back.sv
module hof_back #(
    parameter int SCALE_FRAC_BITS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  hof_pkg::snap_t                  in_snap,
    output logic                            in_take,
    input  logic [hof_pkg::SCALE_BITS-1:0]  scale,
    output logic                            out_valid,
    output hof_pkg::result_t                out_result,
    input  logic                            out_take
);

    localparam int SB    = hof_pkg::SAMPLE_BITS;
    localparam int WIDE  = (SCALE_FRAC_BITS > hof_pkg::SCALE_BITS)
                         ? SCALE_FRAC_BITS : hof_pkg::SCALE_BITS;
    localparam int CMP_W = SB + WIDE;
    localparam int NST   = 8;

    typedef logic [2:0][SB-1:0] trio_t;

    logic [NST:1] valid_reg;
    logic [NST:1] ready;

    // stage payloads
    hof_pkg::window_t win1_reg, win2_reg, win3_reg;
    hof_pkg::sample_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg, c7_reg;
    logic [NST-1:1]   last_reg;
    trio_t            hi1_reg, mid1_reg, lo1_reg;
    trio_t            hi5_reg, mid5_reg, lo5_reg;
    trio_t            agg2_reg, agg6_reg;
    hof_pkg::sample_t m1_3_reg, m1_4_reg, m1_5_reg, m1_6_reg, m1_7_reg;
    hof_pkg::window_t dev4_reg;
    hof_pkg::sample_t dc4_reg, dc5_reg, dc6_reg, dc7_reg;
    hof_pkg::sample_t m2_7_reg;
    hof_pkg::result_t out_reg;

    logic [CMP_W-1:0] lhs, rhs;

    always_comb
    begin
        ready[NST] = !valid_reg[NST] || out_take;
        for (int k = NST - 1; k >= 1; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign in_take    = in_valid && ready[1];
    assign out_valid  = valid_reg[NST];
    assign out_result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int k = 2; k <= NST; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign lhs = CMP_W'(dc7_reg) << SCALE_FRAC_BITS;
    assign rhs = CMP_W'(scale) * CMP_W'(m2_7_reg);

    always_ff @(posedge clk)
    begin
        // sort each row of the window
        if (ready[1])
        begin
            win1_reg    <= in_snap.win;
            c1_reg      <= in_snap.center;
            last_reg[1] <= in_snap.last;
            for (int r = 0; r < 3; r++)
            begin
                hi1_reg[r]  <= hof_pkg::max3(in_snap.win[3*r], in_snap.win[3*r+1],
                                             in_snap.win[3*r+2]);
                mid1_reg[r] <= hof_pkg::med3(in_snap.win[3*r], in_snap.win[3*r+1],
                                             in_snap.win[3*r+2]);
                lo1_reg[r]  <= hof_pkg::min3(in_snap.win[3*r], in_snap.win[3*r+1],
                                             in_snap.win[3*r+2]);
            end
        end
        if (ready[2])
        begin
            win2_reg    <= win1_reg;
            c2_reg      <= c1_reg;
            last_reg[2] <= last_reg[1];
            agg2_reg[0] <= hof_pkg::min3(hi1_reg[0], hi1_reg[1], hi1_reg[2]);
            agg2_reg[1] <= hof_pkg::med3(mid1_reg[0], mid1_reg[1], mid1_reg[2]);
            agg2_reg[2] <= hof_pkg::max3(lo1_reg[0], lo1_reg[1], lo1_reg[2]);
        end
        if (ready[3])
        begin
            win3_reg    <= win2_reg;
            c3_reg      <= c2_reg;
            last_reg[3] <= last_reg[2];
            m1_3_reg    <= hof_pkg::med3(agg2_reg[0], agg2_reg[1], agg2_reg[2]);
        end
        // absolute deviations from the window median
        if (ready[4])
        begin
            for (int i = 0; i < hof_pkg::NSLOT; i++)
            begin
                dev4_reg[i] <= hof_pkg::absdiff(win3_reg[i], m1_3_reg);
            end
            dc4_reg     <= hof_pkg::absdiff(c3_reg, m1_3_reg);
            c4_reg      <= c3_reg;
            m1_4_reg    <= m1_3_reg;
            last_reg[4] <= last_reg[3];
        end
        if (ready[5])
        begin
            for (int r = 0; r < 3; r++)
            begin
                hi5_reg[r]  <= hof_pkg::max3(dev4_reg[3*r], dev4_reg[3*r+1], dev4_reg[3*r+2]);
                mid5_reg[r] <= hof_pkg::med3(dev4_reg[3*r], dev4_reg[3*r+1], dev4_reg[3*r+2]);
                lo5_reg[r]  <= hof_pkg::min3(dev4_reg[3*r], dev4_reg[3*r+1], dev4_reg[3*r+2]);
            end
            dc5_reg     <= dc4_reg;
            c5_reg      <= c4_reg;
            m1_5_reg    <= m1_4_reg;
            last_reg[5] <= last_reg[4];
        end
        if (ready[6])
        begin
            agg6_reg[0] <= hof_pkg::min3(hi5_reg[0], hi5_reg[1], hi5_reg[2]);
            agg6_reg[1] <= hof_pkg::med3(mid5_reg[0], mid5_reg[1], mid5_reg[2]);
            agg6_reg[2] <= hof_pkg::max3(lo5_reg[0], lo5_reg[1], lo5_reg[2]);
            dc6_reg     <= dc5_reg;
            c6_reg      <= c5_reg;
            m1_6_reg    <= m1_5_reg;
            last_reg[6] <= last_reg[5];
        end
        if (ready[7])
        begin
            m2_7_reg    <= hof_pkg::med3(agg6_reg[0], agg6_reg[1], agg6_reg[2]);
            dc7_reg     <= dc6_reg;
            c7_reg      <= c6_reg;
            m1_7_reg    <= m1_6_reg;
            last_reg[7] <= last_reg[6];
        end
        // keep the center unless it lies beyond the scaled spread
        if (ready[8])
        begin
            out_reg.filtered_sample <= (lhs <= rhs) ? c7_reg : m1_7_reg;
            out_reg.result_end      <= last_reg[7];
        end
    end

endmodule

### rtl/hampel_outlier_filter_9tap.sv
// Flow: an accepted request waits in the front queue until the first of the
//   eight back end stages loads it, then moves through them to the result ports.
// Throughput: one request per cycle while the result side keeps popping, set by
//   the fully pipelined median and deviation network; the two-entry queue lets
//   either side stall alone.
// Reset: rst_n clears the window, fill state, held center, queue and pipeline
//   valid bits at once and loads threshold_scale with 72 (4.5 in 4.4 format).
module hampel_outlier_filter_9tap #(
    parameter int SCALE_FRAC_BITS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request side
    input  logic                            push,
    output logic                            full,
    input  hof_pkg::item_t                  item,
    // result side
    output logic                            empty,
    input  logic                            pop,
    output hof_pkg::result_t                result,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hof_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [hof_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [hof_pkg::PDATA_BITS-1:0]  prdata,
    output logic                            pready
);

    logic [hof_pkg::SCALE_BITS-1:0] scale_reg, scale_next;
    logic                           reg_hit;
    logic                           accept;
    hof_pkg::snap_t                 front_snap;
    hof_pkg::snap_t                 q_snap;
    logic                           q_valid;
    logic                           q_take;
    logic                           out_valid;

    // Register decode: the word index sits above the byte offset.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[hof_pkg::PADDR_BITS-1] == hof_pkg::REG_THRESHOLD_SCALE);
    assign prdata  = reg_hit ? hof_pkg::PDATA_BITS'(scale_reg) : '0;

    always_comb
    begin
        scale_next = scale_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            scale_next = pwdata[hof_pkg::SCALE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= hof_pkg::SCALE_RESET;
        end
        else
        begin
            scale_reg <= scale_next;
        end
    end

    // Front end: take a request whenever the queue has room, update the
    // window and pick the center in the same cycle.
    assign accept = push && !full;

    hof_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .snap   (front_snap)
    );

    // Decouple the window update from the median pipeline.
    hof_queue #(
        .WIDTH ($bits(hof_pkg::snap_t)),
        .DEPTH (hof_pkg::QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_snap),
        .full    (full),
        .rd_en   (q_take),
        .rd_data (q_snap),
        .valid   (q_valid)
    );

    // Back end: two medians, the threshold test and the output register.
    hof_back #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_snap    (q_snap),
        .in_take    (q_take),
        .scale      (scale_reg),
        .out_valid  (out_valid),
        .out_result (result),
        .out_take   (pop)
    );

    assign empty = !out_valid;

endmodule

### tb/sv/tb_hampel_outlier_filter_9tap.sv
`timescale 1ns / 1ps

module tb_hampel_outlier_filter_9tap;

    import hof_pkg::*;

    // Scale format of the DUT: unsigned fixed point with this many fraction bits
    localparam int SCALE_FRAC     = 4;
    // Cycles with no request or result moving before the run is declared hung
    localparam int STUCK_LIMIT    = 1000;
    // Drain margin left after the last expected result has come
    localparam int SETTLE_CYCLES  = 12;
    // Length of the one long hold-off on the result side
    localparam int LONG_HOLD      = 300;
    localparam int MAX_REPORTS    = 50;

    localparam logic [PADDR_BITS-1:0] SCALE_ADDR = PADDR_BITS'(REG_THRESHOLD_SCALE) << 2;

    typedef sample_t nine_t [9];

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports (every input known from time zero)
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n   = 1'b0;
    logic                  push    = 1'b0;
    logic                  full;
    item_t                 item    = '0;
    logic                  empty;
    logic                  pop     = 1'b0;
    result_t               result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_BITS-1:0] paddr   = '0;
    logic [PDATA_BITS-1:0] pwdata  = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    hampel_outlier_filter_9tap #(
        .SCALE_FRAC_BITS (SCALE_FRAC)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: window, fill progress, write slot, held center, scale
    // ------------------------------------------------------------------
    nine_t      win_model = '{default: '0};
    phase_t     fill_model = FILL_MID;
    int         slot_model = 0;
    sample_t    held_model = '0;
    logic [7:0] scale_model = SCALE_RESET;

    item_t      request_q [$];       // requests waiting to be offered
    result_t    filtered_due [$];    // predicted results, oldest first

    int         mismatch_count = 0;
    int         results_seen = 0;
    int         stuck_cycles = 0;

    // Handshake bookkeeping between the edge-sampling and edge-driving blocks
    logic       req_taken = 1'b0;
    logic       res_taken = 1'b0;
    logic       rx_long_hold = 1'b0;

    // ------------------------------------------------------------------
    // Median network of the predictor
    // ------------------------------------------------------------------
    function automatic sample_t low3(sample_t a, sample_t b, sample_t c);
        sample_t m;
        m = (b < a) ? b : a;
        return (c < m) ? c : m;
    endfunction

    function automatic sample_t high3(sample_t a, sample_t b, sample_t c);
        sample_t m;
        m = (b > a) ? b : a;
        return (c > m) ? c : m;
    endfunction

    // True middle of three values
    function automatic sample_t mid3(sample_t a, sample_t b, sample_t c);
        if (a > b)
            return (b > c) ? b : ((a > c) ? c : a);
        else
            return (a > c) ? a : ((b > c) ? c : b);
    endfunction

    // Sort each row of the 3x3 grid, then combine the row minima, middles
    // and maxima into the final median
    function automatic sample_t nine_median(nine_t v);
        sample_t row_hi [3];
        sample_t row_md [3];
        sample_t row_lo [3];
        int      r;
        for (r = 0; r < 3; r++)
        begin
            row_hi[r] = high3(v[r*3], v[r*3+1], v[r*3+2]);
            row_md[r] = mid3(v[r*3], v[r*3+1], v[r*3+2]);
            row_lo[r] = low3(v[r*3], v[r*3+1], v[r*3+2]);
        end
        return mid3(low3(row_hi[0], row_hi[1], row_hi[2]),
                    mid3(row_md[0], row_md[1], row_md[2]),
                    high3(row_lo[0], row_lo[1], row_lo[2]));
    endfunction

    function automatic sample_t distance(sample_t a, sample_t b);
        return (a >= b) ? sample_t'(a - b) : sample_t'(b - a);
    endfunction

    // Advance the predictor by one request and return the result it causes
    task automatic hampel_predict(input item_t req, output result_t res);
        sample_t cen;
        sample_t med;
        sample_t mad;
        nine_t   dev;
        int      lhs;
        int      rhs;
        int      i;
        cen = held_model;
        if (slot_model >= 9)
            slot_model = 0;
        case (fill_model)
            FILL_MID:
            begin
                win_model[4] = req.sample;
                fill_model = FILL_INNER;
            end
            FILL_INNER:
            begin
                win_model[3] = req.sample;
                win_model[5] = req.sample;
                fill_model = FILL_MIDDLE;
            end
            FILL_MIDDLE:
            begin
                win_model[2] = req.sample;
                win_model[6] = req.sample;
                fill_model = FILL_OUTER;
            end
            FILL_OUTER:
            begin
                win_model[1] = req.sample;
                win_model[7] = req.sample;
                fill_model = FILL_EDGE;
            end
            FILL_EDGE:
            begin
                // Window full: the first center is the very first sample
                win_model[0] = req.sample;
                win_model[8] = req.sample;
                cen = win_model[4];
                fill_model = STREAM;
                slot_model = 0;
            end
            default:
            begin
                // Overwrite the oldest slot; the center trails by four samples
                win_model[slot_model] = req.sample;
                cen = win_model[(slot_model + 5) % 9];
                slot_model = (slot_model + 1) % 9;
                fill_model = STREAM;
            end
        endcase
        held_model = cen;

        med = nine_median(win_model);
        for (i = 0; i < 9; i++)
            dev[i] = distance(win_model[i], med);
        mad = nine_median(dev);

        lhs = int'(distance(cen, med)) << SCALE_FRAC;
        rhs = int'(scale_model) * int'(mad);
        res.filtered_sample = (lhs <= rhs) ? cen : med;
        res.result_end = req.frame_end;

        // Frame end: restart the fill, keep the window and held center
        if (req.frame_end)
        begin
            fill_model = FILL_MID;
            slot_model = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch on %s at result %0d: got %0h, expected %0h",
                     what, results_seen, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Idle draws: each side switches between no idling, light and heavy
    // idling every couple of dozen requests
    // ------------------------------------------------------------------
    function automatic int draw_wait(int style);
        case (style)
            0:       return 0;
            1:       return $urandom_range(0, 2);
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sampling at the rising edge: predict accepted requests, check
    // accepted results, run the watchdog
    // ------------------------------------------------------------------
    result_t want_res;
    result_t new_res;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (filtered_due.size() == 0)
                begin
                    report_mismatch("result with none pending", result, 0);
                end
                else
                begin
                    want_res = filtered_due.pop_front();
                    if (result.filtered_sample !== want_res.filtered_sample)
                        report_mismatch("filtered_sample", result.filtered_sample,
                                        want_res.filtered_sample);
                    if (result.result_end !== want_res.result_end)
                        report_mismatch("result_end", result.result_end,
                                        want_res.result_end);
                end
                results_seen++;
                res_taken = 1'b1;
            end
            if (push && !full)
            begin
                hampel_predict(item, new_res);
                filtered_due.push_back(new_res);
                req_taken = 1'b1;
            end

            if ((pop && !empty) || (push && !full))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver: drop the accepted request, wait out the drawn gap,
    // then offer the next one from the queue
    // ------------------------------------------------------------------
    logic  push_next;
    item_t item_next;
    int    tx_wait = 0;
    int    tx_style = 0;
    int    tx_draws = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            push_next = push;
            item_next = item;
            if (push && req_taken)
            begin
                req_taken = 1'b0;
                void'(request_q.pop_front());
                if (tx_draws % 24 == 0)
                    tx_style = $urandom_range(0, 2);
                tx_draws++;
                tx_wait = draw_wait(tx_style);
                push_next = 1'b0;
            end
            if (!push_next)
            begin
                if (tx_wait > 0)
                    tx_wait--;
                else if (request_q.size() != 0)
                begin
                    push_next = 1'b1;
                    item_next = request_q[0];
                end
            end
            push <= push_next;
            item <= item_next;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: hold pop low for the drawn gap after each result,
    // or for the whole long hold-off when one is requested
    // ------------------------------------------------------------------
    logic pop_next;
    int   rx_wait = 0;
    int   rx_style = 0;
    int   rx_draws = 0;
    int   hold_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            pop_next = pop;
            if (pop && res_taken)
            begin
                res_taken = 1'b0;
                if (rx_draws % 24 == 0)
                    rx_style = $urandom_range(0, 2);
                rx_draws++;
                rx_wait = draw_wait(rx_style);
                pop_next = 1'b0;
            end
            if (rx_long_hold)
            begin
                rx_long_hold = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop_next = 1'b0;
            end
            else if (!pop_next)
            begin
                if (rx_wait > 0)
                    rx_wait--;
                else
                    pop_next = 1'b1;
            end
            pop <= pop_next;
        end
    end

    // ------------------------------------------------------------------
    // Register access: setup cycle, then access cycle until pready
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [PADDR_BITS-1:0] addr, input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= PDATA_BITS'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        scale_model = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Read the scale back and compare with the predictor's copy
    task automatic check_scale_readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SCALE_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[7:0] !== scale_model)
            report_mismatch("threshold_scale readback", prdata[7:0], scale_model);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input int value, input logic last);
        item_t req;
        req.sample = sample_t'(value);
        req.frame_end = last;
        request_q.push_back(req);
    endtask

    // One frame of random shape: uniform noise, a drifting level with
    // spikes, rail-to-rail extremes, or a flat level with rare outliers
    task automatic queue_frame(input int len);
        int shape;
        int level;
        int v;
        int k;
        shape = $urandom_range(0, 3);
        level = $urandom_range(0, 255);
        for (k = 0; k < len; k++)
        begin
            case (shape)
                0: v = $urandom_range(0, 255);
                1:
                begin
                    v = level + $urandom_range(0, 8) - 4;
                    level = v;
                    if ($urandom_range(0, 7) == 0)
                        v = $urandom_range(0, 255);
                end
                2: v = $urandom_range(0, 1) ? 255 : 0;
                default: v = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : level;
            endcase
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            if (level < 0)
                level = 0;
            if (level > 255)
                level = 255;
            queue_item(v, k == len - 1);
        end
    endtask

    // Mostly full frames; a few end during the fill, a few run long
    task automatic queue_frames(input int count);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 3)
                len = $urandom_range(1, 5);
            else if (pick == 19)
                len = $urandom_range(50, 90);
            else
                len = $urandom_range(6, 30);
            queue_frame(len);
            sent += len;
        end
    endtask

    // Hold the sender until every expected result has come, then let the
    // pipeline settle before touching the register
    task automatic wait_drained;
        while (request_q.size() != 0 || filtered_due.size() != 0 || push)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    logic [7:0] scale_plan [6];
    int         p;

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset value of the scale
        check_scale_readback();

        // Frame that ends during the fill: the held center is repeated
        queue_item(255, 1'b0);
        queue_item(0, 1'b0);
        queue_item(128, 1'b0);
        queue_item(1, 1'b1);
        // Full frame with a flat level, a high and a low spike and both rails
        queue_item(10, 1'b0);
        queue_item(10, 1'b0);
        queue_item(10, 1'b0);
        queue_item(10, 1'b0);
        queue_item(10, 1'b0);
        queue_item(10, 1'b0);
        queue_item(250, 1'b0);
        queue_item(10, 1'b0);
        queue_item(10, 1'b0);
        queue_item(10, 1'b0);
        queue_item(0, 1'b0);
        queue_item(10, 1'b0);
        queue_item(10, 1'b0);
        queue_item(255, 1'b0);
        queue_item(10, 1'b0);
        queue_item(10, 1'b1);
        // Single-request frame
        queue_item(77, 1'b1);
        wait_drained();

        queue_frames(60);
        wait_drained();

        scale_plan[0] = 8'd0;
        scale_plan[1] = 8'd255;
        scale_plan[2] = 8'd1;
        scale_plan[3] = 8'd16;
        scale_plan[4] = 8'($urandom_range(0, 255));
        scale_plan[5] = 8'($urandom_range(0, 255));

        for (p = 0; p < 6; p++)
        begin
            reg_write(SCALE_ADDR, scale_plan[p]);
            check_scale_readback();
            queue_frames(70);
            // Stall the result side long enough to back up into the input
            if (p == 1)
                rx_long_hold = 1'b1;
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
